>>> rtl/line_rasterizer_macros.svh
// ---------------------------------------------------------------------------
// line rasterizer assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ---------------------------------------------------------------------------
`ifndef LINE_RASTERIZER_MACROS_SVH
`define LINE_RASTERIZER_MACROS_SVH

// same-cycle implication
`define LR_ASSERT_IMP(label, cond, chk, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (chk)) \
    else $error(msg);

// next-cycle implication
`define LR_ASSERT_NXT(label, cond, chk, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (chk)) \
    else $error(msg);

`endif

>>> rtl/lr_pkg.sv
// ---------------------------------------------------------------------------
// lr_pkg
// widths, opcodes and the classified line item shared by the rasterizer
// ---------------------------------------------------------------------------
package lr_pkg;

  localparam int COORD_BITS   = 10;
  localparam int COLOR_BITS   = 8;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int DIV_CNT_BITS = $clog2(COORD_BITS);

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [COLOR_BITS-1:0] color_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_e;

  // item after classification in the front end
  typedef struct packed {
    op_e    op;
    logic   nonvert;   // endpoints differ in x
    logic   walk_up;   // first endpoint is the left one
    logic   dy_neg;    // second endpoint lies above the first
    coord_t anchor_x;
    coord_t anchor_y;
    coord_t walk_pos;
    coord_t walk_lim;
    coord_t abs_dx;
    coord_t abs_dy;
    color_t red;
    color_t green;
    color_t blue;
  } line_item_t;

endpackage

>>> rtl/lr_cmd_if.sv
// ---------------------------------------------------------------------------
// lr_cmd_if
// command channel: line loads and pixel steps
// ---------------------------------------------------------------------------
interface lr_cmd_if import lr_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   operation;
  coord_t x_start;
  coord_t y_start;
  coord_t x_end;
  coord_t y_end;
  color_t red_in;
  color_t green_in;
  color_t blue_in;

  modport source (
    output valid, operation, x_start, y_start, x_end, y_end, red_in, green_in, blue_in,
    input  ready
  );
  modport sink (
    input  valid, operation, x_start, y_start, x_end, y_end, red_in, green_in, blue_in,
    output ready
  );
endinterface

>>> rtl/lr_pix_if.sv
// ---------------------------------------------------------------------------
// lr_pix_if
// pixel channel: one beat per emitted pixel
// ---------------------------------------------------------------------------
interface lr_pix_if import lr_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t pixel_x;
  coord_t pixel_y;
  color_t red_out;
  color_t green_out;
  color_t blue_out;
  logic   last_pixel;

  modport source (
    output valid, pixel_x, pixel_y, red_out, green_out, blue_out, last_pixel,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, red_out, green_out, blue_out, last_pixel,
    output ready
  );
endinterface

>>> rtl/line_rasterizer.sv
// ---------------------------------------------------------------------------
// line_rasterizer
// walks a loaded line while it is active and emits one pixel per step beat
// ---------------------------------------------------------------------------
//  channel  dir  handshake       payload
//  cmd_i    in   valid / ready   operation, endpoints, color
//  pix_o    out  valid / ready   pixel_x, pixel_y, color, last_pixel
//
//  an accepted step's pixel is registered; steps run one per cycle while pix_o is ready
//  a non-vertical load goes through walker intake, then a bit-serial divide
//  a vertical or single-point load needs only intake, with no divide, in the walker
//  a QUEUE_DEPTH-entry fifo sits between command intake and walker
//  a stalled pixel holds its register; the walker waits, then the fifo fills
//  asynchronous reset clears all control state; no line is active afterwards
// ---------------------------------------------------------------------------
module line_rasterizer import lr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  lr_cmd_if.sink   cmd_i,
  lr_pix_if.source pix_o
);

  line_item_t push_item, head_item;
  logic       push, full, pop, empty;

  // intake and classification
  lr_front u_front (
    .cmd_i  (cmd_i),
    .full_i (full),
    .push_o (push),
    .item_o (push_item)
  );

  // decoupling fifo
  lr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head_item)
  );

  // walker
  lr_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head_item),
    .empty_i (empty),
    .pop_o   (pop),
    .pix_o   (pix_o)
  );

endmodule

>>> rtl/lr_front.sv
// ---------------------------------------------------------------------------
// lr_front
// accepts command beats and classifies loads: walk axis, walk range, deltas
// ---------------------------------------------------------------------------
module lr_front import lr_pkg::*; (
  lr_cmd_if.sink     cmd_i,
  input  logic       full_i,
  output logic       push_o,
  output line_item_t item_o
);

  coord_t x_lo, x_hi, y_lo, y_hi;
  logic   walk_up, dy_neg, nonvert;

  // accept whenever the queue has room
  assign cmd_i.ready = !full_i;
  assign push_o      = cmd_i.valid && !full_i;

  // endpoint ordering
  always_comb begin
    nonvert = cmd_i.x_start != cmd_i.x_end;
    walk_up = cmd_i.x_start < cmd_i.x_end;
    dy_neg  = cmd_i.y_end < cmd_i.y_start;
    x_lo    = walk_up ? cmd_i.x_start : cmd_i.x_end;
    x_hi    = walk_up ? cmd_i.x_end : cmd_i.x_start;
    y_lo    = dy_neg ? cmd_i.y_end : cmd_i.y_start;
    y_hi    = dy_neg ? cmd_i.y_start : cmd_i.y_end;
  end

  // classified item
  always_comb begin
    item_o.op       = op_e'(cmd_i.operation);
    item_o.nonvert  = nonvert;
    item_o.walk_up  = walk_up;
    item_o.dy_neg   = dy_neg;
    item_o.anchor_x = cmd_i.x_start;
    item_o.anchor_y = cmd_i.y_start;
    item_o.abs_dx   = x_hi - x_lo;
    item_o.abs_dy   = y_hi - y_lo;
    item_o.red      = cmd_i.red_in;
    item_o.green    = cmd_i.green_in;
    item_o.blue     = cmd_i.blue_in;
    if (nonvert) begin
      item_o.walk_pos = x_lo;
      item_o.walk_lim = x_hi;
    end else if (y_lo != y_hi) begin
      // vertical: the end with the larger y is left out
      item_o.walk_pos = y_lo;
      item_o.walk_lim = y_hi - coord_t'(1);
    end else begin
      item_o.walk_pos = cmd_i.y_start;
      item_o.walk_lim = cmd_i.y_start;
    end
  end

endmodule

>>> rtl/lr_queue.sv
// ---------------------------------------------------------------------------
// lr_queue
// short fifo of classified items between front and back
// ---------------------------------------------------------------------------
module lr_queue import lr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  line_item_t push_item_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       empty_o,
  output line_item_t head_o
);

  line_item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QPTR_BITS:0]     count_q;

  assign full_o  = count_q == (QPTR_BITS+1)'(QUEUE_DEPTH);
  assign empty_o = count_q == '0;
  assign head_o  = mem_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

>>> rtl/lr_back.sv
// ---------------------------------------------------------------------------
// lr_back
// line walker: slope divide on a non-vertical load, incremental quotient stepping per pixel
// ---------------------------------------------------------------------------
`include "line_rasterizer_macros.svh"

module lr_back import lr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  line_item_t head_i,
  input  logic       empty_i,
  output logic       pop_o,
  lr_pix_if.source   pix_o
);

  typedef enum logic {
    ST_RUN,
    ST_DIV
  } state_e;

  state_e                  st_q, st_d;
  logic                    active_q, active_d;
  logic                    nonvert_q, nonvert_d;
  logic                    up_q, up_d;
  logic                    dy_neg_q, dy_neg_d;
  coord_t                  anchor_x_q, anchor_x_d;
  coord_t                  anchor_y_q, anchor_y_d;
  coord_t                  walk_pos_q, walk_pos_d;
  coord_t                  walk_lim_q, walk_lim_d;
  coord_t                  abs_dx_q, abs_dx_d;
  coord_t                  div_quo_q, div_quo_d;   // becomes the whole-step part
  coord_t                  div_rem_q, div_rem_d;   // becomes the fractional step
  logic [DIV_CNT_BITS-1:0] div_cnt_q, div_cnt_d;
  coord_t                  q_acc_q, q_acc_d;
  coord_t                  r_acc_q, r_acc_d;
  color_t                  red_q, red_d, green_q, green_d, blue_q, blue_d;
  logic                    pix_valid_q, pix_valid_d;
  coord_t                  pix_x_q, pix_x_d, pix_y_q, pix_y_d;
  color_t                  pix_r_q, pix_r_d, pix_g_q, pix_g_d, pix_b_q, pix_b_d;
  logic                    pix_last_q, pix_last_d;

  logic                    out_free, pop, emit, last;
  logic [COORD_BITS:0]     trial, sum_up;
  logic                    trial_ge, carry, borrow;
  coord_t                  r_up, r_dn, q_up, q_dn;

  // handshake with queue and output register
  assign out_free = !pix_valid_q || pix_o.ready;
  assign pop      = (st_q == ST_RUN) && !empty_i &&
                    (head_i.op == OP_LOAD || !active_q || out_free);
  assign emit     = pop && head_i.op == OP_STEP && active_q;
  assign last     = walk_pos_q == walk_lim_q;
  assign pop_o    = pop;

  // one restoring divide step
  always_comb begin
    trial    = {div_rem_q, div_quo_q[COORD_BITS-1]};
    trial_ge = trial >= {1'b0, abs_dx_q};
    sum_up   = trial - {1'b0, abs_dx_q};
  end

  // quotient and remainder stepping, forward and backward
  always_comb begin
    logic [COORD_BITS:0] r_sum;
    r_sum  = {1'b0, r_acc_q} + {1'b0, div_rem_q};
    carry  = r_sum >= {1'b0, abs_dx_q};
    r_up   = carry ? coord_t'(r_sum - {1'b0, abs_dx_q}) : r_sum[COORD_BITS-1:0];
    q_up   = q_acc_q + div_quo_q + coord_t'(carry);
    borrow = r_acc_q < div_rem_q;
    r_dn   = borrow ? r_acc_q + abs_dx_q - div_rem_q : r_acc_q - div_rem_q;
    q_dn   = q_acc_q - div_quo_q - coord_t'(borrow);
  end

  // next-state logic
  always_comb begin
    st_d        = st_q;
    active_d    = active_q;
    nonvert_d   = nonvert_q;
    up_d        = up_q;
    dy_neg_d    = dy_neg_q;
    anchor_x_d  = anchor_x_q;
    anchor_y_d  = anchor_y_q;
    walk_pos_d  = walk_pos_q;
    walk_lim_d  = walk_lim_q;
    abs_dx_d    = abs_dx_q;
    div_quo_d   = div_quo_q;
    div_rem_d   = div_rem_q;
    div_cnt_d   = div_cnt_q;
    q_acc_d     = q_acc_q;
    r_acc_d     = r_acc_q;
    red_d       = red_q;
    green_d     = green_q;
    blue_d      = blue_q;
    pix_valid_d = pix_o.ready ? 1'b0 : pix_valid_q;
    pix_x_d     = pix_x_q;
    pix_y_d     = pix_y_q;
    pix_r_d     = pix_r_q;
    pix_g_d     = pix_g_q;
    pix_b_d     = pix_b_q;
    pix_last_d  = pix_last_q;

    unique case (st_q)
      ST_RUN: begin
        if (pop && head_i.op == OP_LOAD) begin
          // new line replaces any walk in progress
          active_d   = 1'b1;
          nonvert_d  = head_i.nonvert;
          up_d       = head_i.walk_up;
          dy_neg_d   = head_i.dy_neg;
          anchor_x_d = head_i.anchor_x;
          anchor_y_d = head_i.anchor_y;
          walk_pos_d = head_i.walk_pos;
          walk_lim_d = head_i.walk_lim;
          abs_dx_d   = head_i.abs_dx;
          div_quo_d  = head_i.abs_dy;
          div_rem_d  = '0;
          div_cnt_d  = '0;
          q_acc_d    = head_i.walk_up ? '0 : head_i.abs_dy;
          r_acc_d    = '0;
          red_d      = head_i.red;
          green_d    = head_i.green;
          blue_d     = head_i.blue;
          if (head_i.nonvert) begin
            st_d = ST_DIV;
          end
        end else if (emit) begin
          pix_valid_d = 1'b1;
          pix_x_d     = nonvert_q ? walk_pos_q : anchor_x_q;
          pix_y_d     = !nonvert_q ? walk_pos_q :
                        (dy_neg_q ? anchor_y_q - q_acc_q : anchor_y_q + q_acc_q);
          pix_r_d     = red_q;
          pix_g_d     = green_q;
          pix_b_d     = blue_q;
          pix_last_d  = last;
          if (last) begin
            active_d = 1'b0;
          end else begin
            walk_pos_d = walk_pos_q + coord_t'(1);
            q_acc_d    = up_q ? q_up : q_dn;
            r_acc_d    = up_q ? r_up : r_dn;
          end
        end
      end
      ST_DIV: begin
        div_quo_d = {div_quo_q[COORD_BITS-2:0], trial_ge};
        div_rem_d = trial_ge ? sum_up[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
        div_cnt_d = div_cnt_q + 1'b1;
        if (div_cnt_q == DIV_CNT_BITS'(COORD_BITS-1)) begin
          st_d = ST_RUN;
        end
      end
      default: st_d = ST_RUN;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_RUN;
      active_q    <= 1'b0;
      nonvert_q   <= 1'b0;
      up_q        <= 1'b0;
      dy_neg_q    <= 1'b0;
      anchor_x_q  <= '0;
      anchor_y_q  <= '0;
      walk_pos_q  <= '0;
      walk_lim_q  <= '0;
      abs_dx_q    <= '0;
      div_quo_q   <= '0;
      div_rem_q   <= '0;
      div_cnt_q   <= '0;
      q_acc_q     <= '0;
      r_acc_q     <= '0;
      red_q       <= '0;
      green_q     <= '0;
      blue_q      <= '0;
      pix_valid_q <= 1'b0;
      pix_x_q     <= '0;
      pix_y_q     <= '0;
      pix_r_q     <= '0;
      pix_g_q     <= '0;
      pix_b_q     <= '0;
      pix_last_q  <= 1'b0;
    end else begin
      st_q        <= st_d;
      active_q    <= active_d;
      nonvert_q   <= nonvert_d;
      up_q        <= up_d;
      dy_neg_q    <= dy_neg_d;
      anchor_x_q  <= anchor_x_d;
      anchor_y_q  <= anchor_y_d;
      walk_pos_q  <= walk_pos_d;
      walk_lim_q  <= walk_lim_d;
      abs_dx_q    <= abs_dx_d;
      div_quo_q   <= div_quo_d;
      div_rem_q   <= div_rem_d;
      div_cnt_q   <= div_cnt_d;
      q_acc_q     <= q_acc_d;
      r_acc_q     <= r_acc_d;
      red_q       <= red_d;
      green_q     <= green_d;
      blue_q      <= blue_d;
      pix_valid_q <= pix_valid_d;
      pix_x_q     <= pix_x_d;
      pix_y_q     <= pix_y_d;
      pix_r_q     <= pix_r_d;
      pix_g_q     <= pix_g_d;
      pix_b_q     <= pix_b_d;
      pix_last_q  <= pix_last_d;
    end
  end

  // pixel channel
  assign pix_o.valid      = pix_valid_q;
  assign pix_o.pixel_x    = pix_x_q;
  assign pix_o.pixel_y    = pix_y_q;
  assign pix_o.red_out    = pix_r_q;
  assign pix_o.green_out  = pix_g_q;
  assign pix_o.blue_out   = pix_b_q;
  assign pix_o.last_pixel = pix_last_q;

  // checks
  `LR_ASSERT_IMP(a_div_holds_queue, st_q == ST_DIV, !pop, "item taken during slope divide")
  `LR_ASSERT_IMP(a_rem_in_range, active_q && nonvert_q && st_q == ST_RUN, r_acc_q < abs_dx_q, "step remainder out of range")
  `LR_ASSERT_NXT(a_last_ends_line, emit && last, !active_q, "line still active after last pixel")
  `LR_ASSERT_IMP(a_walk_order, active_q, walk_pos_q <= walk_lim_q, "walk passed its limit")

endmodule

>>> sim/lr_pixel_checker.sv
// ---------------------------------------------------------------------------
// lr_pixel_checker
// watches the command and pixel channels of the line rasterizer, predicts
// each pixel from the accepted commands and compares every emitted beat
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lr_pixel_checker import lr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  lr_cmd_if    cmd_i,
  lr_pix_if    pix_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   pixels_checked_o
);

  typedef struct packed {
    coord_t x;
    coord_t y;
    color_t red;
    color_t green;
    color_t blue;
    logic   last;
  } pixel_t;

  // predicted pixels still waiting for their beat
  pixel_t expected_pixels[$];

  // current line as the walker sees it
  logic   line_busy;
  coord_t p0_x, p0_y, p1_x, p1_y;
  coord_t walk_at, walk_end;
  color_t line_red, line_green, line_blue;

  int fails;
  int pixels_checked;

  assign fail_count_o     = fails;
  assign pixels_checked_o = pixels_checked;

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      fails++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t want;
    int     dx, dy, offset;
    if (!rst_ni) begin
      line_busy  = 1'b0;
      p0_x       = '0;
      p0_y       = '0;
      p1_x       = '0;
      p1_y       = '0;
      walk_at    = '0;
      walk_end   = '0;
      line_red   = '0;
      line_green = '0;
      line_blue  = '0;
      expected_pixels.delete();
      pending_o <= 0;
    end else begin
      // compare an emitted pixel with the oldest prediction
      if (pix_i.valid && pix_i.ready) begin
        pixels_checked++;
        if (expected_pixels.size() == 0) begin
          fails++;
          $display("%0t: unexpected pixel beat, expected none, got x=%0d y=%0d last=%0d",
                   $time, pix_i.pixel_x, pix_i.pixel_y, pix_i.last_pixel);
        end else begin
          want = expected_pixels.pop_front();
          check_field("pixel_x", want.x, pix_i.pixel_x);
          check_field("pixel_y", want.y, pix_i.pixel_y);
          check_field("red_out", want.red, pix_i.red_out);
          check_field("green_out", want.green, pix_i.green_out);
          check_field("blue_out", want.blue, pix_i.blue_out);
          check_field("last_pixel", want.last, pix_i.last_pixel);
        end
      end

      // track loads and predict the pixel of each step
      if (cmd_i.valid && cmd_i.ready) begin
        if (cmd_i.operation == OP_LOAD) begin
          p0_x       = cmd_i.x_start;
          p0_y       = cmd_i.y_start;
          p1_x       = cmd_i.x_end;
          p1_y       = cmd_i.y_end;
          line_red   = cmd_i.red_in;
          line_green = cmd_i.green_in;
          line_blue  = cmd_i.blue_in;
          if (p0_x != p1_x) begin
            walk_at  = (p0_x < p1_x) ? p0_x : p1_x;
            walk_end = (p0_x < p1_x) ? p1_x : p0_x;
          end else if (p0_y != p1_y) begin
            // vertical walk stops short of the larger end
            walk_at  = (p0_y < p1_y) ? p0_y : p1_y;
            walk_end = ((p0_y < p1_y) ? p1_y : p0_y) - coord_t'(1);
          end else begin
            walk_at  = p0_y;
            walk_end = p0_y;
          end
          line_busy = 1'b1;
        end else if (line_busy) begin
          if (p0_x != p1_x) begin
            // y from the slope, quotient truncated toward zero
            dx     = int'(p1_x) - int'(p0_x);
            dy     = int'(p1_y) - int'(p0_y);
            offset = int'(walk_at) - int'(p0_x);
            want.x = walk_at;
            want.y = coord_t'(int'(p0_y) + (dy * offset) / dx);
          end else begin
            want.x = p0_x;
            want.y = walk_at;
          end
          want.red   = line_red;
          want.green = line_green;
          want.blue  = line_blue;
          want.last  = (walk_at == walk_end);
          if (want.last) line_busy = 1'b0;
          else walk_at = walk_at + coord_t'(1);
          // append at the tail
          expected_pixels = {expected_pixels, want};
        end
      end
      pending_o <= expected_pixels.size();
    end
  end

endmodule

>>> sim/tb_line_rasterizer.sv
// ---------------------------------------------------------------------------
// tb_line_rasterizer
// drives loads and steps into the line rasterizer with random idling on
// both channels; a separate checker predicts and compares every pixel
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_line_rasterizer import lr_pkg::*; ();

  localparam int RANDOM_ITEMS = 1100;
  localparam int HOLD_CYCLES  = 120;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_GAP      = 20;
  localparam int TIMEOUT_NS   = 3_000_000;

  logic clk_i;
  logic rst_ni;

  lr_cmd_if cmd ();
  lr_pix_if pix ();

  int fail_count;
  int pending;
  int pixels_checked;

  // idling knobs and stall requests shared with the receiver
  int tx_idle_pct;
  int rx_stall_pct;
  int hold_requests;

  // bookkeeping of the stimulus
  int loads_sent;
  int steps_sent;
  int line_left;
  int counted;

  line_rasterizer uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .pix_o  (pix)
  );

  lr_pixel_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .pix_i            (pix),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .pixels_checked_o (pixels_checked)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #TIMEOUT_NS;
    $display("timeout with %0d pixels outstanding", pending);
    $display("CHECKS FAILED");
    $finish;
  end

  // pixel receiver: random stalls plus long hold-offs on request
  initial begin
    int hold_left;
    int hold_served;
    pix.ready   = 1'b0;
    hold_left   = 0;
    hold_served = 0;
    forever begin
      @(posedge clk_i);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pix.ready <= 1'b0;
      end else begin
        pix.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // one command beat, preceded by a random idle gap
  task automatic send_cmd(input op_e op, input coord_t xs, input coord_t ys,
                          input coord_t xe, input coord_t ye,
                          input color_t r, input color_t g, input color_t b);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd.valid     <= 1'b1;
    cmd.operation <= op;
    cmd.x_start   <= xs;
    cmd.y_start   <= ys;
    cmd.x_end     <= xe;
    cmd.y_end     <= ye;
    cmd.red_in    <= r;
    cmd.green_in  <= g;
    cmd.blue_in   <= b;
    do @(posedge clk_i); while (!cmd.ready);
    if (op == OP_LOAD) begin
      loads_sent++;
      counted++;
      if (xs != xe) line_left = (xs > xe ? int'(xs) - int'(xe) : int'(xe) - int'(xs)) + 1;
      else if (ys != ye) line_left = (ys > ye ? int'(ys) - int'(ye) : int'(ye) - int'(ys));
      else line_left = 1;
    end else begin
      steps_sent++;
      if (line_left > 0) begin
        line_left--;
        counted++;
      end
    end
  endtask

  // step beats carry random payload, which the block ignores
  task automatic step_pixels(input int n);
    for (int i = 0; i < n; i++)
      send_cmd(OP_STEP, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
               coord_t'($urandom), color_t'($urandom), color_t'($urandom),
               color_t'($urandom));
  endtask

  // mostly short lines near a random point, now and then a wide one
  task automatic load_random_line(input bit wide);
    int span_x, span_y, x0, y0, x1, y1, shape;
    span_x = wide ? 1023 : 12;
    span_y = wide ? 1023 : 40;
    x0 = $urandom_range(1023);
    y0 = $urandom_range(1023);
    x1 = $urandom_range(x0 > span_x ? x0 - span_x : 0, x0 + span_x < 1023 ? x0 + span_x : 1023);
    y1 = $urandom_range(y0 > span_y ? y0 - span_y : 0, y0 + span_y < 1023 ? y0 + span_y : 1023);
    shape = $urandom_range(99);
    if (shape < 15) begin
      x1 = x0;
    end else if (shape < 20) begin
      x1 = x0;
      y1 = y0;
    end
    send_cmd(OP_LOAD, coord_t'(x0), coord_t'(y0), coord_t'(x1), coord_t'(y1),
             color_t'($urandom), color_t'($urandom), color_t'($urandom));
  endtask

  // stop offering commands until every predicted pixel has come out
  task automatic wait_drained();
    cmd.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // stimulus and verdict
  initial begin
    int kind;
    int target;
    cmd.valid      = 1'b0;
    cmd.operation  = OP_LOAD;
    cmd.x_start    = '0;
    cmd.y_start    = '0;
    cmd.x_end      = '0;
    cmd.y_end      = '0;
    cmd.red_in     = '0;
    cmd.green_in   = '0;
    cmd.blue_in    = '0;
    tx_idle_pct    = 0;
    rx_stall_pct   = 0;
    hold_requests  = 0;
    loads_sent     = 0;
    steps_sent     = 0;
    line_left      = 0;
    counted        = 0;
    rst_ni         = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: step with no line, then a single point walked past its end
    step_pixels(1);
    send_cmd(OP_LOAD, 10'd0, 10'd0, 10'd0, 10'd0, 8'd0, 8'd0, 8'd0);
    step_pixels(2);
    // single point at the far corner, full color
    send_cmd(OP_LOAD, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 8'd255, 8'd255, 8'd255);
    step_pixels(1);
    // steep line given right to left
    send_cmd(OP_LOAD, 10'd5, 10'd0, 10'd2, 10'd1023, 8'h80, 8'h01, 8'hfe);
    step_pixels(4);
    // vertical lines in both directions
    send_cmd(OP_LOAD, 10'd1023, 10'd1023, 10'd1023, 10'd1020, 8'h55, 8'haa, 8'h0f);
    step_pixels(3);
    send_cmd(OP_LOAD, 10'd0, 10'd0, 10'd0, 10'd2, 8'h0f, 8'h55, 8'haa);
    step_pixels(2);
    // full diagonal replaced by a new load mid-walk
    send_cmd(OP_LOAD, 10'd0, 10'd1023, 10'd1023, 10'd0, 8'h12, 8'h34, 8'h56);
    step_pixels(2);
    send_cmd(OP_LOAD, 10'd1021, 10'd0, 10'd1023, 10'd1, 8'hed, 8'hcb, 8'ha9);
    step_pixels(3);
    wait_drained();

    // long output stall while steps keep coming
    send_cmd(OP_LOAD, 10'd0, 10'd0, 10'd63, 10'd500, 8'h3c, 8'hc3, 8'h99);
    hold_requests++;
    step_pixels(64);
    wait_drained();

    // random phases: receiver stalls most, then sender idles most, then neither
    counted = 0;
    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct  = (phase == 0) ? 36 : (phase == 1) ? 74 : 0;
      rx_stall_pct = (phase == 0) ? 74 : (phase == 1) ? 36 : 0;
      target       = RANDOM_ITEMS * (phase + 1) / 3;
      while (counted < target) begin
        kind = $urandom_range(99);
        if (kind < 75) begin
          // whole line, sometimes with stray steps after its end
          load_random_line($urandom_range(99) == 0);
          step_pixels(line_left + (($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0));
        end else if (kind < 88) begin
          // line cut short by the next load
          load_random_line(1'b0);
          step_pixels($urandom_range(line_left - 1));
        end else if (kind < 94) begin
          step_pixels($urandom_range(1, 3));
        end else begin
          load_random_line(1'b1);
        end
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("run: %0d loads and %0d steps sent, %0d pixels compared",
             loads_sent, steps_sent, pixels_checked);
    $display("run: directed corner lines, a %0d-cycle output stall, three idling mixes",
             HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
